// ===== rtl/swms_pkg.sv =====
// Package: shared constants, types and helpers for the sliding-window statistics block.
`timescale 1ns / 1ps
package swms_pkg;

	localparam int WINDOW_MAX = 1024;
	localparam int DIM_MAX    = 64;

	localparam int SLOT_W     = $clog2(WINDOW_MAX);
	localparam int DIM_W      = $clog2(DIM_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int NDIM_W     = $clog2(DIM_MAX + 1);
	localparam int HIST_DEPTH = WINDOW_MAX * DIM_MAX;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	localparam int WIN_CFG_W  = 11;
	localparam int DIM_CFG_W  = 7;
	localparam int IDX_W      = 6;
	localparam int VAL_W      = 16;
	localparam int VSQ_W      = 2 * VAL_W;
	localparam int SUM_W      = 26;
	localparam int SQ_W       = 42;
	localparam int SQ_OUT_W   = 41;
	localparam int FRM_W      = 11;

	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = PADDR_W - 2;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [WIN_CFG_W-1:0] WINDOW_RST = WIN_CFG_W'(600);
	localparam logic [DIM_CFG_W-1:0] DIM_RST    = DIM_CFG_W'(13);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WINDOW_FRAMES  = REG_IDX_W'(0),
		REG_FEATURE_DIM    = REG_IDX_W'(1),
		REG_TRACK_VARIANCE = REG_IDX_W'(2)
	} reg_idx_t;

	typedef struct packed {
		logic [WIN_CFG_W-1:0] window_frames;
		logic [DIM_CFG_W-1:0] feature_dim;
		logic                 track_variance;
	} swms_cfg_t;

	typedef struct packed {
		logic [DIM_W-1:0]   dim;
		logic [HIST_AW-1:0] hist_addr;
		logic [VAL_W-1:0]   val;
		logic [VSQ_W-1:0]   val_sq;
		logic               full;
		logic [CNT_W-1:0]   count;
		logic               eof;
	} swms_entry_t;

	function automatic logic [CNT_W-1:0] clamp_window(input logic [WIN_CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > WINDOW_MAX) begin
			r = CNT_W'(WINDOW_MAX);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	function automatic logic [NDIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
		logic [NDIM_W-1:0] r;
		if (v == '0) begin
			r = NDIM_W'(1);
		end else if (int'(v) > DIM_MAX) begin
			r = NDIM_W'(DIM_MAX);
		end else begin
			r = NDIM_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/swms_if.sv =====
// Interfaces: input and output word channels with valid/ready handshake.
`timescale 1ns / 1ps
interface swms_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [swms_pkg::VAL_W-1:0]  feature_value;

	modport source (output valid, output feature_value, input ready);
	modport sink   (input valid, input feature_value, output ready);
endinterface

interface swms_out_if;
	logic                                valid;
	logic                                ready;
	logic [swms_pkg::IDX_W-1:0]          dim_index;
	logic signed [swms_pkg::SUM_W-1:0]   window_sum;
	logic [swms_pkg::SQ_OUT_W-1:0]       window_sum_sq;
	logic [swms_pkg::FRM_W-1:0]          frames_in_window;
	logic                                end_of_frame;

	modport source (output valid, output dim_index, output window_sum, output window_sum_sq,
		output frames_in_window, output end_of_frame, input ready);
	modport sink   (input valid, input dim_index, input window_sum, input window_sum_sq,
		input frames_in_window, input end_of_frame, output ready);
endinterface

// ===== rtl/sliding_window_mean_var_stats_top.sv =====
// Top level: sliding-window sum and sum-of-squares statistics per feature dimension.
`timescale 1ns / 1ps
// Channel | Dir | Word
// in_ch   | in  | feature_value (signed Q8.8)
// out_ch  | out | dim_index, window_sum, window_sum_sq, frames_in_window, end_of_frame
// apb     | in  | window_frames @0x0, feature_dim @0x4, track_variance @0x8
//
// One word in and one word out per cycle while the output is not stalled; each word passes
// through the queue, then the memory read stage, then the sum update into the output register.
// Rate is set by the single read-modify-write of the per-dimension sum memory, with a bypass
// for back-to-back words on the same dimension. Output stalls back up through a two-entry queue.
// Reset clears counters and sum valid flags; no clearing pass: the history memory must be read
// only once written, which the block itself does not enforce.
module sliding_window_mean_var_stats_top (
	input  logic                         clk,
	input  logic                         arst_n,
	swms_in_if.sink                      in_ch,
	swms_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swms_pkg::PADDR_W-1:0] paddr,
	input  logic [swms_pkg::PDATA_W-1:0] pwdata,
	output logic [swms_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import swms_pkg::*;

	swms_cfg_t   cfg;
	logic        push_valid;
	logic        push_ready;
	swms_entry_t push_data;
	logic        pop_valid;
	logic        pop_ready;
	swms_entry_t pop_data;

	swms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	swms_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	swms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_ch    (out_ch)
	);
endmodule

// ===== rtl/swms_cfg.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module swms_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swms_pkg::PADDR_W-1:0] paddr,
	input  logic [swms_pkg::PDATA_W-1:0] pwdata,
	output logic [swms_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output swms_pkg::swms_cfg_t          cfg
);
	import swms_pkg::*;

	swms_cfg_t cfg_q;
	reg_idx_t  reg_idx;
	logic      wr_en;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_frames  <= WINDOW_RST;
			cfg_q.feature_dim    <= DIM_RST;
			cfg_q.track_variance <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW_FRAMES:  cfg_q.window_frames  <= pwdata[WIN_CFG_W-1:0];
				REG_FEATURE_DIM:    cfg_q.feature_dim    <= pwdata[DIM_CFG_W-1:0];
				REG_TRACK_VARIANCE: cfg_q.track_variance <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW_FRAMES:  prdata = PDATA_W'(cfg_q.window_frames);
			REG_FEATURE_DIM:    prdata = PDATA_W'(cfg_q.feature_dim);
			REG_TRACK_VARIANCE: prdata = PDATA_W'(cfg_q.track_variance);
			default:            prdata = '0;
		endcase
	end
endmodule

// ===== rtl/swms_front.sv =====
// Front end: accept words, track dimension, slot and frame count, classify into queue entries.
`timescale 1ns / 1ps
module swms_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swms_pkg::swms_cfg_t   cfg,
	swms_in_if.sink               in_ch,
	output logic                  push_valid,
	input  logic                  push_ready,
	output swms_pkg::swms_entry_t push_data
);
	import swms_pkg::*;

	logic [DIM_W-1:0]    dim_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    seen_q;

	logic [CNT_W-1:0]    win;
	logic [NDIM_W-1:0]   ndim;
	logic [CNT_W:0]      seen_inc;
	logic [CNT_W-1:0]    count;
	logic [SLOT_W:0]     slot_inc;
	logic                slot_wrap;
	logic                eof;
	logic                accept;
	logic signed [VSQ_W-1:0] val_sq;

	assign win      = clamp_window(cfg.window_frames);
	assign ndim     = clamp_dim(cfg.feature_dim);
	assign seen_inc = (CNT_W + 1)'(seen_q) + (CNT_W + 1)'(1);
	assign count    = (seen_inc > (CNT_W + 1)'(win)) ? win : seen_inc[CNT_W-1:0];
	assign slot_inc = (SLOT_W + 1)'(slot_q) + (SLOT_W + 1)'(1);
	assign slot_wrap = int'(slot_inc) >= int'(win);
	assign eof      = (int'(dim_q) + 1) >= int'(ndim);
	assign val_sq   = in_ch.feature_value * in_ch.feature_value;

	assign push_valid  = in_ch.valid;
	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;

	always_comb begin
		push_data.dim       = dim_q;
		push_data.hist_addr = HIST_AW'(slot_q) * HIST_AW'(DIM_MAX) + HIST_AW'(dim_q);
		push_data.val       = in_ch.feature_value;
		push_data.val_sq    = val_sq;
		push_data.full      = seen_q >= win;
		push_data.count     = count;
		push_data.eof       = eof;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= '0;
			slot_q <= '0;
			seen_q <= '0;
		end else if (accept) begin
			if (eof) begin
				dim_q  <= '0;
				slot_q <= slot_wrap ? '0 : slot_inc[SLOT_W-1:0];
				seen_q <= count;
			end else begin
				dim_q  <= dim_q + DIM_W'(1);
			end
		end
	end
endmodule

// ===== rtl/swms_fifo.sv =====
// Short queue between front end and back end.
`timescale 1ns / 1ps
module swms_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  swms_pkg::swms_entry_t push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output swms_pkg::swms_entry_t pop_data
);
	import swms_pkg::*;

	swms_entry_t         slot_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]  wr_ptr_q;
	logic [FIFO_PW-1:0]  rd_ptr_q;
	logic [FIFO_CW-1:0]  fill_q;
	logic                push;
	logic                pop;

	assign push_ready = fill_q != FIFO_CW'(FIFO_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + FIFO_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + FIFO_PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FIFO_CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FIFO_CW'(1);
			end
		end
	end
endmodule

// ===== rtl/swms_back.sv =====
// Back end: history and sum memories, read-modify-write of window sums, output register.
`timescale 1ns / 1ps
module swms_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swms_pkg::swms_cfg_t   cfg,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  swms_pkg::swms_entry_t pop_data,
	swms_out_if.source            out_ch
);
	import swms_pkg::*;

	logic [VAL_W-1:0] hist_mem [HIST_DEPTH];
	logic [SUM_W-1:0] sum_mem  [DIM_MAX];
	logic [SQ_W-1:0]  sq_mem   [DIM_MAX];
	logic             vld_q    [DIM_MAX];

	logic             adv;
	logic             pop;
	logic             wr;

	logic             valid_s1;
	logic             fwd_s1;
	logic             vld_rd_s1;
	swms_entry_t      ent_s1;
	logic [VAL_W-1:0] hist_rd_s1;
	logic [SUM_W-1:0] sum_rd_s1;
	logic [SQ_W-1:0]  sq_rd_s1;

	logic [SUM_W-1:0] wb_sum_q;
	logic [SQ_W-1:0]  wb_sq_q;

	logic [SUM_W-1:0] base_sum;
	logic [SQ_W-1:0]  base_sq;
	logic signed [VAL_W-1:0] new_val;
	logic signed [VAL_W-1:0] old_val;
	logic signed [VSQ_W-1:0] old_sq;
	logic [SUM_W-1:0] sum_new;
	logic [SQ_W-1:0]  sq_new;

	logic                   out_valid_q;
	logic [IDX_W-1:0]       out_dim_q;
	logic [SUM_W-1:0]       out_sum_q;
	logic [SQ_OUT_W-1:0]    out_sq_q;
	logic [FRM_W-1:0]       out_cnt_q;
	logic                   out_eof_q;

	assign adv       = !out_valid_q || out_ch.ready;
	assign pop_ready = adv;
	assign pop       = pop_valid && adv;
	assign wr        = valid_s1 && adv;

	always_ff @(posedge clk) begin
		if (pop) begin
			hist_rd_s1                  <= hist_mem[pop_data.hist_addr];
			hist_mem[pop_data.hist_addr] <= pop_data.val;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_rd_s1 <= sum_mem[pop_data.dim];
			sq_rd_s1  <= sq_mem[pop_data.dim];
		end
		if (wr) begin
			sum_mem[ent_s1.dim] <= sum_new;
			sq_mem[ent_s1.dim]  <= sq_new;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1 <= pop_data;
		end
		if (wr) begin
			wb_sum_q  <= sum_new;
			wb_sq_q   <= sq_new;
			out_dim_q <= IDX_W'(ent_s1.dim);
			out_sum_q <= sum_new;
			out_sq_q  <= sq_new[SQ_OUT_W-1:0];
			out_cnt_q <= FRM_W'(ent_s1.count);
			out_eof_q <= ent_s1.eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			vld_rd_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIM_MAX; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (adv) begin
				valid_s1    <= pop_valid;
				out_valid_q <= valid_s1;
			end
			if (pop) begin
				fwd_s1    <= valid_s1 && (ent_s1.dim == pop_data.dim);
				vld_rd_s1 <= vld_q[pop_data.dim];
			end
			if (wr) begin
				vld_q[ent_s1.dim] <= 1'b1;
			end
		end
	end

	always_comb begin
		priority if (fwd_s1) begin
			base_sum = wb_sum_q;
			base_sq  = wb_sq_q;
		end else if (vld_rd_s1) begin
			base_sum = sum_rd_s1;
			base_sq  = sq_rd_s1;
		end else begin
			base_sum = '0;
			base_sq  = '0;
		end
	end

	assign new_val = $signed(ent_s1.val);
	assign old_val = $signed(hist_rd_s1);
	assign old_sq  = old_val * old_val;

	always_comb begin
		sum_new = base_sum + SUM_W'(new_val);
		sq_new  = base_sq + SQ_W'(ent_s1.val_sq);
		if (ent_s1.full) begin
			sum_new = sum_new - SUM_W'(old_val);
			sq_new  = sq_new - SQ_W'($unsigned(old_sq));
		end
		if (!cfg.track_variance) begin
			sq_new = '0;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.dim_index        = out_dim_q;
	assign out_ch.window_sum       = $signed(out_sum_q);
	assign out_ch.window_sum_sq    = out_sq_q;
	assign out_ch.frames_in_window = out_cnt_q;
	assign out_ch.end_of_frame     = out_eof_q;
endmodule

// ===== rtl/swms_checker.sv =====
// Checker: port-level assertions for the statistics block, bound to the top level.
`timescale 1ns / 1ps
module swms_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [swms_pkg::IDX_W-1:0]   dim_index,
	input logic [swms_pkg::SUM_W-1:0]   window_sum,
	input logic [swms_pkg::FRM_W-1:0]   frames_in_window,
	input logic                         end_of_frame
);
	import swms_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dim_index) && $stable(window_sum)
			&& $stable(frames_in_window) && $stable(end_of_frame))
		else $error("output word changed while stalled");

	a_frames_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frames_in_window != '0 && int'(frames_in_window) <= WINDOW_MAX)
		else $error("frame count out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without an output stall");

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(dim_index) < DIM_MAX)
		else $error("dimension index out of range");
endmodule

bind sliding_window_mean_var_stats_top swms_checker u_swms_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.dim_index        (out_ch.dim_index),
	.window_sum       (out_ch.window_sum),
	.frames_in_window (out_ch.frames_in_window),
	.end_of_frame     (out_ch.end_of_frame)
);

// ===== verif/sliding_window_mean_var_stats_top_tb.sv =====
// Testbench: streams feature words through the window statistics block and checks every result word.
`timescale 1ns / 1ps
module sliding_window_mean_var_stats_top_tb;
	import swms_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_WORDS = 650;
	localparam int LONG_HOLD = 150;

	typedef struct packed {
		logic [DIM_W-1:0]  dim;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  frames;
	} walk_t;

	typedef struct packed {
		logic [DIM_W-1:0]   d;
		logic [HIST_AW-1:0] addr;
		logic [CNT_W-1:0]   count;
		logic               full;
		logic               eof;
		walk_t              next;
	} hop_t;

	typedef struct packed {
		logic [IDX_W-1:0]           dim_index;
		logic signed [SUM_W-1:0]    window_sum;
		logic [SQ_OUT_W-1:0]        window_sum_sq;
		logic [FRM_W-1:0]           frames_in_window;
		logic                       end_of_frame;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	swms_in_if in_ch();
	swms_out_if out_ch();

	sliding_window_mean_var_stats_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [WIN_CFG_W-1:0] cfg_window = WINDOW_RST;
	logic [DIM_CFG_W-1:0] cfg_dim = DIM_RST;
	logic                 cfg_var = 1'b0;

	logic signed [VAL_W-1:0] past_value [HIST_DEPTH];
	logic signed [SUM_W-1:0] run_sum [DIM_MAX] = '{default: '0};
	logic [SQ_W-1:0]         run_sum_sq [DIM_MAX] = '{default: '0};
	walk_t                   pred_walk = '0;

	walk_t plan_walk = '0;
	bit    plan_written [HIST_DEPTH];

	logic signed [VAL_W-1:0] feature_q [$];
	stats_t                  stats_due_q [$];
	int fed_total = 0;
	int taken_total = 0;
	int errs = 0;
	int idle_cycles = 0;
	logic in_taken = 1'b0;

	int gap_left = 0;
	int burst_left = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int rx_mode = 0;
	int mode_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic hop_t walk_step(walk_t s, logic [WIN_CFG_W-1:0] win,
		logic [DIM_CFG_W-1:0] nd_reg);
		hop_t h;
		int w;
		int nd;
		w = (win == '0) ? 1 : ((int'(win) > WINDOW_MAX) ? WINDOW_MAX : int'(win));
		nd = (nd_reg == '0) ? 1 : ((int'(nd_reg) > DIM_MAX) ? DIM_MAX : int'(nd_reg));
		h.d = s.dim;
		h.addr = {s.slot, s.dim};
		h.full = int'(s.frames) >= w;
		h.count = (int'(s.frames) + 1 > w) ? CNT_W'(w) : CNT_W'(int'(s.frames) + 1);
		h.eof = int'(s.dim) + 1 >= nd;
		if (h.eof) begin
			h.next.dim = '0;
			h.next.slot = (int'(s.slot) + 1 >= w) ? '0 : SLOT_W'(int'(s.slot) + 1);
			h.next.frames = h.count;
		end else begin
			h.next.dim = DIM_W'(int'(s.dim) + 1);
			h.next.slot = s.slot;
			h.next.frames = s.frames;
		end
		return h;
	endfunction

	function automatic stats_t predict_stats(logic signed [VAL_W-1:0] x);
		hop_t h;
		stats_t r;
		longint v;
		longint old;
		longint acc_sum;
		longint acc_sq;
		h = walk_step(pred_walk, cfg_window, cfg_dim);
		v = x;
		acc_sum = run_sum[h.d] + v;
		acc_sq = longint'(run_sum_sq[h.d]) + v * v;
		if (h.full) begin
			old = past_value[h.addr];
			acc_sum = acc_sum - old;
			acc_sq = acc_sq - old * old;
		end
		if (!cfg_var) begin
			acc_sq = 0;
		end
		run_sum[h.d] = acc_sum[SUM_W-1:0];
		run_sum_sq[h.d] = acc_sq[SQ_W-1:0];
		past_value[h.addr] = x;
		pred_walk = h.next;
		r.dim_index = h.d;
		r.window_sum = acc_sum[SUM_W-1:0];
		r.window_sum_sq = acc_sq[SQ_OUT_W-1:0];
		r.frames_in_window = h.count;
		r.end_of_frame = h.eof;
		return r;
	endfunction

	function automatic bit queue_feature(logic signed [VAL_W-1:0] x);
		hop_t h;
		h = walk_step(plan_walk, cfg_window, cfg_dim);
		// drop any word that would pull a never-written history entry
		if (h.full && !plan_written[h.addr]) begin
			return 1'b0;
		end
		plan_written[h.addr] = 1'b1;
		plan_walk = h.next;
		feature_q.insert(feature_q.size(), x);
		fed_total++;
		return 1'b1;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] x;
		case ($urandom_range(0, 7))
			0: x = 16'sh8000;
			1: x = 16'sh7FFF;
			2: x = 16'sh0000;
			3: x = 16'shFFFF;
			default: x = VAL_W'($urandom_range(0, 65535));
		endcase
		return x;
	endfunction

	function automatic void flag_field(string field, logic signed [63:0] want,
		logic signed [63:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", field, want, got);
			errs++;
		end
	endfunction

	task automatic drain();
		while (taken_total != fed_total || stats_due_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_WINDOW_FRAMES: cfg_window = value[WIN_CFG_W-1:0];
			REG_FEATURE_DIM: cfg_dim = value[DIM_CFG_W-1:0];
			REG_TRACK_VARIANCE: cfg_var = value[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int unsigned win, input int unsigned nd,
		input int unsigned var_on);
		drain();
		reg_write(REG_WINDOW_FRAMES, PDATA_W'(win));
		reg_write(REG_FEATURE_DIM, PDATA_W'(nd));
		reg_write(REG_TRACK_VARIANCE, PDATA_W'(var_on));
		@(posedge clk);
	endtask

	// sender: bursts of random length with random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (feature_q.size() != 0) begin
				in_ch.valid <= 1'b1;
				in_ch.feature_value <= feature_q[0];
				feature_q.delete(0);
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: stall modes of its own, plus one long hold-off under load
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && feature_q.size() > 20) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					default: out_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		stats_t got;
		stats_t want;
		in_taken <= in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.dim_index = out_ch.dim_index;
				got.window_sum = out_ch.window_sum;
				got.window_sum_sq = out_ch.window_sum_sq;
				got.frames_in_window = out_ch.frames_in_window;
				got.end_of_frame = out_ch.end_of_frame;
				if (stats_due_q.size() == 0) begin
					$error("result word with no prediction pending");
					errs++;
				end else begin
					want = stats_due_q[0];
					stats_due_q.delete(0);
					flag_field("dim_index", want.dim_index, got.dim_index);
					flag_field("window_sum", want.window_sum, got.window_sum);
					flag_field("window_sum_sq", want.window_sum_sq, got.window_sum_sq);
					flag_field("frames_in_window", want.frames_in_window,
						got.frames_in_window);
					flag_field("end_of_frame", want.end_of_frame, got.end_of_frame);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				stats_due_q.insert(stats_due_q.size(), predict_stats(in_ch.feature_value));
				taken_total++;
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [VAL_W-1:0] edge_vals [$];
		int random_fed;
		int n;
		int unsigned win;
		int unsigned nd;
		edge_vals = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'h5555, 16'hAAAA,
			16'h8000, 16'h7FFF, 16'h8000};
		random_fed = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.feature_value = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_config(2, 3, 1);
		foreach (edge_vals[i]) begin
			if (!queue_feature(edge_vals[i])) break;
		end
		// window and dimension count of zero, squares off
		set_config(0, 0, 0);
		void'(queue_feature(16'sh8000));
		void'(queue_feature(16'sh7FFF));
		void'(queue_feature(16'shFFFF));
		void'(queue_feature(16'sh0001));
		// both counts above their maximum
		set_config(2047, 127, 1);
		repeat (6) void'(queue_feature(16'sh7FFF));

		while (random_fed < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0: win = $urandom_range(9, 40);
				1: begin
					case ($urandom_range(0, 4))
						0: win = 0;
						1: win = 1;
						2: win = WINDOW_MAX;
						3: win = WINDOW_MAX + 1;
						default: win = 2047;
					endcase
				end
				2: win = $urandom_range(0, 2047);
				default: win = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 19))
				0, 1, 2: begin
					case ($urandom_range(0, 5))
						0: nd = 0;
						1: nd = 1;
						2: nd = DIM_MAX - 1;
						3: nd = DIM_MAX;
						4: nd = DIM_MAX + 1;
						default: nd = 127;
					endcase
				end
				3, 4, 5: nd = $urandom_range(1, DIM_MAX);
				default: nd = $urandom_range(1, 8);
			endcase
			set_config(win, nd, $urandom_range(0, 1));
			n = $urandom_range(8, 60);
			for (int k = 0; k < n; k++) begin
				if (!queue_feature(pick_value())) break;
				random_fed++;
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errs == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
